### design/bayer_white_balance_gain_macros.svh
// Assertion macros shared by the white balance gain RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BAYER_WHITE_BALANCE_GAIN_MACROS_SVH
`define BAYER_WHITE_BALANCE_GAIN_MACROS_SVH

// Property checked on every rising edge of clk, idle while reset is held.
`define BWB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BWB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bwb_pkg.sv
// Package of the Bayer white balance gain block: types, register codes,
// reset values and the color filter site tables. No dependencies.
`default_nettype none

package bwb_pkg;

	// Default parameter values.
	localparam int PIXEL_BITS_DEFAULT     = 24;
	localparam int GAIN_FRAC_BITS_DEFAULT = 12;

	// Fixed register widths.
	localparam int GAIN_BITS      = 16;
	localparam int DEPTH_BITS     = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Queue depths.
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ENABLE   = 3'd0,
		REG_CFA      = 3'd1,
		REG_R_GAIN   = 3'd2,
		REG_B_GAIN   = 3'd3,
		REG_PX_DEPTH = 3'd4
	} reg_idx_t;

	// Bayer orders.
	typedef enum logic [1:0] {
		CFA_RGGB = 2'd0,
		CFA_BGGR = 2'd1,
		CFA_GRBG = 2'd2,
		CFA_GBRG = 2'd3
	} cfa_t;

	// Treatment of one pixel in the back end.
	typedef enum logic [1:0] {
		CLS_GREEN = 2'd0,
		CLS_RED   = 2'd1,
		CLS_BLUE  = 2'd2,
		CLS_PASS  = 2'd3
	} cls_t;

	// Register file contents handed from the front to the back.
	typedef struct packed {
		logic                  enable;
		cfa_t                  cfa;
		logic [GAIN_BITS-1:0]  r_gain;
		logic [GAIN_BITS-1:0]  b_gain;
		logic [DEPTH_BITS-1:0] px_depth;
	} cfg_t;

	// Reset values.
	localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd4096;
	localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 5'd12;

	// Row parity of the red site for each order.
	function automatic logic red_row(input cfa_t cfa);
		logic r;
		case (cfa)
			CFA_RGGB: r = 1'b0;
			CFA_BGGR: r = 1'b1;
			CFA_GRBG: r = 1'b0;
			CFA_GBRG: r = 1'b1;
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	// Column parity of the red site for each order.
	function automatic logic red_col(input cfa_t cfa);
		logic c;
		case (cfa)
			CFA_RGGB: c = 1'b0;
			CFA_BGGR: c = 1'b1;
			CFA_GRBG: c = 1'b1;
			CFA_GBRG: c = 1'b0;
			default:  c = 1'b0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### design/bayer_white_balance_gain.sv
// Top level of the Bayer white balance gain block.
// Depends on bwb_pkg, bwb_front, bwb_fifo and bwb_back.
//
// Usage:
//   Pixels enter in raster order with line and frame end marks. An item is
//   taken at a rising edge with push high and full low. Results leave the
//   same way a queue is read: the oldest result sits on the output ports
//   while empty is low and is taken at an edge with pop high.
//   Registers are written through cfg_we, cfg_index and cfg_data while the
//   block is idle: 0 enable, 1 Bayer order, 2 red gain, 3 blue gain,
//   4 bit depth. Gains are unsigned Q4.12.
//   A result passes the middle queue, the multiply stage, the round and
//   clip stage and the result queue. Throughput: one item per cycle while
//   the receiver keeps popping, set by the single multiplier stage and
//   the issue check against the four-entry result queue.
//   When the receiver stalls, the result queue fills, issue stops, the
//   two-entry middle queue fills and full rises; no item is dropped.
//   Reset clears the queues, the parity (first row and column even) and
//   loads the register defaults: enabled, RGGB, unity gains, 12 bits.
`default_nettype none

module bayer_white_balance_gain import bwb_pkg::*; #(
	parameter int PIXEL_BITS     = PIXEL_BITS_DEFAULT,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [PIXEL_BITS-1:0]     pixel_in,
	input  wire logic                      line_end_in,
	input  wire logic                      frame_end_in,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [PIXEL_BITS-1:0]          pixel_out,
	output logic                           line_end_out,
	output logic                           frame_end_out
);

	localparam int MID_W = PIXEL_BITS + 4;

	cfg_t             cfg;
	logic             mid_push;
	logic [MID_W-1:0] mid_wdata;
	logic             mid_full;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rdata;
	logic             mid_empty;

	assign full = mid_full;

	// Front end: registers, parity and classification.
	bwb_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.q_full      (mid_full),
		.pixel_in    (pixel_in),
		.line_end_in (line_end_in),
		.frame_end_in(frame_end_in),
		.q_push      (mid_push),
		.q_data      (mid_wdata),
		.cfg         (cfg)
	);

	// Short queue between the front and back ends.
	bwb_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty),
		.count ()
	);

	// Back end: gain, rounding, clipping and the result queue.
	bwb_back #(
		.PIXEL_BITS    (PIXEL_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (mid_empty),
		.q_data       (mid_rdata),
		.q_pop        (mid_pop),
		.empty        (empty),
		.pop          (pop),
		.pixel_out    (pixel_out),
		.line_end_out (line_end_out),
		.frame_end_out(frame_end_out)
	);

endmodule

`default_nettype wire

### design/bwb_fifo.sv
// Small register-based first-in first-out queue.
// Depends on nothing; used for the middle queue and the result queue.
`default_nettype none

module bwb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// Status and handshake qualification.
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage array, written at the tail.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/bwb_front.sv
// Front end: configuration registers, row and column parity tracking and
// classification of each accepted pixel. Depends on bwb_pkg and the macros.
`default_nettype none
`include "bayer_white_balance_gain_macros.svh"

module bwb_front import bwb_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      push,
	input  wire logic                      q_full,
	input  wire logic [PIXEL_BITS-1:0]     pixel_in,
	input  wire logic                      line_end_in,
	input  wire logic                      frame_end_in,
	output logic                           q_push,
	output logic [PIXEL_BITS+3:0]          q_data,
	output cfg_t                           cfg
);

	cfg_t cfg_q;
	logic row_odd_q;
	logic col_odd_q;
	logic accept;
	logic is_red;
	logic is_blue;
	cls_t cls;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b1;
			cfg_q.cfa      <= CFA_RGGB;
			cfg_q.r_gain   <= GAIN_RESET;
			cfg_q.b_gain   <= GAIN_RESET;
			cfg_q.px_depth <= DEPTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:   cfg_q.enable   <= cfg_data[0];
				REG_CFA:      cfg_q.cfa      <= cfa_t'(cfg_data[1:0]);
				REG_R_GAIN:   cfg_q.r_gain   <= cfg_data[GAIN_BITS-1:0];
				REG_B_GAIN:   cfg_q.b_gain   <= cfg_data[GAIN_BITS-1:0];
				REG_PX_DEPTH: cfg_q.px_depth <= cfg_data[DEPTH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg    = cfg_q;
	assign accept = push && !q_full;

	// Site classification from the current parity.
	always_comb begin
		is_red  = (row_odd_q == red_row(cfg_q.cfa)) && (col_odd_q == red_col(cfg_q.cfa));
		is_blue = (row_odd_q != red_row(cfg_q.cfa)) && (col_odd_q != red_col(cfg_q.cfa));
		if (!cfg_q.enable) begin
			cls = CLS_PASS;
		end else if (is_red) begin
			cls = CLS_RED;
		end else if (is_blue) begin
			cls = CLS_BLUE;
		end else begin
			cls = CLS_GREEN;
		end
	end

	assign q_push = accept;
	assign q_data = {cls, frame_end_in, line_end_in, pixel_in};

	// Parity tracking: frame end clears both, line end starts the next row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_odd_q <= 1'b0;
			col_odd_q <= 1'b0;
		end else if (accept) begin
			if (frame_end_in) begin
				row_odd_q <= 1'b0;
				col_odd_q <= 1'b0;
			end else if (line_end_in) begin
				row_odd_q <= ~row_odd_q;
				col_odd_q <= 1'b0;
			end else begin
				col_odd_q <= ~col_odd_q;
			end
		end
	end

	// A frame end always brings the next pixel back to the first site.
	`BWB_ASSERT_NEXT(a_frame_restart, accept && frame_end_in, !row_odd_q && !col_odd_q,
		"parity not cleared after frame end")

endmodule

`default_nettype wire

### design/bwb_back.sv
// Back end: gain multiply, rounding and clipping in two stages, and the
// result queue. Depends on bwb_pkg, bwb_fifo and the macros.
`default_nettype none
`include "bayer_white_balance_gain_macros.svh"

module bwb_back import bwb_pkg::*; #(
	parameter int PIXEL_BITS     = PIXEL_BITS_DEFAULT,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  q_empty,
	input  wire logic [PIXEL_BITS+3:0] q_data,
	output logic                       q_pop,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [PIXEL_BITS-1:0]      pixel_out,
	output logic                       line_end_out,
	output logic                       frame_end_out
);

	localparam int PROD_BITS = PIXEL_BITS + GAIN_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int RND_BITS  = SUM_BITS - GAIN_FRAC_BITS;
	localparam int CEIL_BITS = PIXEL_BITS + 1;
	localparam int DEPTH_W   = $clog2(PIXEL_BITS + 1);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
	localparam int OUT_W     = PIXEL_BITS + 2;

	logic [PIXEL_BITS-1:0] q_pixel;
	logic                  q_le;
	logic                  q_fe;
	cls_t                  q_cls;
	logic [GAIN_BITS-1:0]  gain;
	logic [PROD_BITS-1:0]  prod;

	logic                  v1_s1;
	logic [PROD_BITS-1:0]  prod_s1;
	logic                  clip_s1;
	logic                  le_s1;
	logic                  fe_s1;

	logic [SUM_BITS-1:0]   sum;
	logic [RND_BITS-1:0]   rnd;
	logic [DEPTH_W-1:0]    depth;
	logic [CEIL_BITS-1:0]  ceil_full;
	logic [PIXEL_BITS-1:0] ceiling;
	logic [PIXEL_BITS-1:0] result;

	logic                  v2_s2;
	logic [PIXEL_BITS-1:0] pix_s2;
	logic                  le_s2;
	logic                  fe_s2;

	logic [CNT_W-1:0]      out_count;
	logic                  out_full;
	logic [CNT_W:0]        in_flight;
	logic [OUT_W-1:0]      out_data;

	assign {q_cls, q_fe, q_le, q_pixel} = q_data;

	// Issue only while the result queue has room for everything in flight.
	assign in_flight = (CNT_W+1)'(out_count) + (CNT_W+1)'(v1_s1) + (CNT_W+1)'(v2_s2);
	assign q_pop     = !q_empty && (in_flight < (CNT_W+1)'(OUT_DEPTH));

	// Gain selection and the single multiplier.
	always_comb begin
		gain = (q_cls == CLS_RED) ? cfg.r_gain : cfg.b_gain;
		prod = PROD_BITS'(q_pixel) * PROD_BITS'(gain);
	end

	// Stage 1: product, or the pixel aligned to the fraction for unity gain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else begin
			v1_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if ((q_cls == CLS_RED) || (q_cls == CLS_BLUE)) begin
				prod_s1 <= prod;
			end else begin
				prod_s1 <= PROD_BITS'(q_pixel) << GAIN_FRAC_BITS;
			end
			clip_s1 <= (q_cls != CLS_PASS);
			le_s1   <= q_le;
			fe_s1   <= q_fe;
		end
	end

	// Clip ceiling from the bit depth, clamped to one through the pixel width.
	always_comb begin
		if (cfg.px_depth == '0) begin
			depth = DEPTH_W'(1);
		end else if (32'(cfg.px_depth) > PIXEL_BITS) begin
			depth = DEPTH_W'(PIXEL_BITS);
		end else begin
			depth = DEPTH_W'(cfg.px_depth);
		end
		ceil_full = (CEIL_BITS'(1) << depth) - CEIL_BITS'(1);
		ceiling   = ceil_full[PIXEL_BITS-1:0];
	end

	// Round half up, drop the fraction, then saturate unless passed through.
	always_comb begin
		sum = SUM_BITS'(prod_s1) + (SUM_BITS'(1) << (GAIN_FRAC_BITS - 1));
		rnd = RND_BITS'(sum >> GAIN_FRAC_BITS);
		if (clip_s1 && (rnd > RND_BITS'(ceiling))) begin
			result = ceiling;
		end else begin
			result = rnd[PIXEL_BITS-1:0];
		end
	end

	// Stage 2: finished result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v1_s1) begin
			pix_s2 <= result;
			le_s2  <= le_s1;
			fe_s2  <= fe_s1;
		end
	end

	// Result queue facing the receiver.
	bwb_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v2_s2),
		.wdata ({fe_s2, le_s2, pix_s2}),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_data),
		.empty (empty),
		.count (out_count)
	);

	assign {frame_end_out, line_end_out, pixel_out} = out_data;

	// The room check must keep the result queue from ever overflowing.
	`BWB_ASSERT(a_no_overflow, !(v2_s2 && out_full), "result queue written while full")
	`BWB_ASSERT(a_in_flight, in_flight <= (CNT_W+1)'(OUT_DEPTH),
		"more items in flight than result queue entries")
	`BWB_ASSERT_NEXT(a_issue_reaches_s2, v1_s1, v2_s2, "item lost between stages")

endmodule

`default_nettype wire

### tb/bwb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Bayer white balance gain block: follows register writes,
// predicts every pixel and compares results in order. Depends on bwb_pkg.
module bwb_checker import bwb_pkg::*; #(
	parameter int PIXEL_BITS     = PIXEL_BITS_DEFAULT,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      push,
	input  wire logic                      full,
	input  wire logic [PIXEL_BITS-1:0]     pixel_in,
	input  wire logic                      line_end_in,
	input  wire logic                      frame_end_in,
	input  wire logic                      empty,
	input  wire logic                      pop,
	input  wire logic [PIXEL_BITS-1:0]     pixel_out,
	input  wire logic                      line_end_out,
	input  wire logic                      frame_end_out,
	output int                             mismatches,
	output int                             pending,
	output int                             compared
);

	// One pixel with its marks, as it enters or leaves the block.
	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  line_end;
		logic                  frame_end;
	} sample_t;

	sample_t               expected_pixels[$];
	logic                  wb_enable;
	cfa_t                  wb_cfa;
	logic [GAIN_BITS-1:0]  wb_r_gain;
	logic [GAIN_BITS-1:0]  wb_b_gain;
	logic [DEPTH_BITS-1:0] wb_depth;
	logic                  row_odd;
	logic                  col_odd;

	// Gain, round and clip one raw pixel at the current Bayer site.
	function automatic logic [PIXEL_BITS-1:0] gained_pixel(input logic [PIXEL_BITS-1:0] raw);
		logic [63:0] acc;
		logic [63:0] gain;
		logic [63:0] ceiling;
		logic        red_row_odd;
		logic        red_col_odd;
		int          bits;
		acc = raw;
		if (wb_enable) begin
			// Red sits on an odd row for BGGR and GBRG, on an odd column for BGGR and GRBG.
			red_row_odd = (wb_cfa == CFA_BGGR) || (wb_cfa == CFA_GBRG);
			red_col_odd = (wb_cfa == CFA_BGGR) || (wb_cfa == CFA_GRBG);
			if (row_odd == red_row_odd && col_odd == red_col_odd) begin
				gain = wb_r_gain;
				acc  = (acc * gain + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
			end else if (row_odd != red_row_odd && col_odd != red_col_odd) begin
				gain = wb_b_gain;
				acc  = (acc * gain + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
			end
			// Depth zero behaves as one bit, anything wider than the port as the port.
			bits = wb_depth;
			if (bits < 1)
				bits = 1;
			if (bits > PIXEL_BITS)
				bits = PIXEL_BITS;
			ceiling = (64'd1 << bits) - 64'd1;
			if (acc > ceiling)
				acc = ceiling;
		end
		return acc[PIXEL_BITS-1:0];
	endfunction

	// Track registers, predict accepted pixels and check popped results.
	always @(posedge clk or negedge arst_n) begin
		sample_t got;
		sample_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			wb_enable  = 1'b1;
			wb_cfa     = CFA_RGGB;
			wb_r_gain  = GAIN_RESET;
			wb_b_gain  = GAIN_RESET;
			wb_depth   = DEPTH_RESET;
			row_odd    = 1'b0;
			col_odd    = 1'b0;
			mismatches = 0;
			pending    = 0;
			compared   = 0;
		end else begin
			// Register writes; indexes past the list change nothing.
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:   wb_enable = cfg_data[0];
					REG_CFA:      wb_cfa    = cfa_t'(cfg_data[1:0]);
					REG_R_GAIN:   wb_r_gain = cfg_data[GAIN_BITS-1:0];
					REG_B_GAIN:   wb_b_gain = cfg_data[GAIN_BITS-1:0];
					REG_PX_DEPTH: wb_depth  = cfg_data[DEPTH_BITS-1:0];
					default: ;
				endcase
			end

			// A result leaves the block.
			if (pop && !empty) begin
				got.pixel     = pixel_out;
				got.line_end  = line_end_out;
				got.frame_end = frame_end_out;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with nothing expected, got pixel %h le %b fe %b",
						$time, got.pixel, got.line_end, got.frame_end);
				end else begin
					want = expected_pixels.pop_front();
					compared++;
					if (got.pixel !== want.pixel || got.line_end !== want.line_end ||
							got.frame_end !== want.frame_end) begin
						mismatches++;
						$display("%0t ns: expected pixel %h le %b fe %b, got pixel %h le %b fe %b",
							$time, want.pixel, want.line_end, want.frame_end,
							got.pixel, got.line_end, got.frame_end);
					end
				end
			end

			// An item enters: predict, then move the site parity on.
			if (push && !full) begin
				want.pixel     = gained_pixel(pixel_in);
				want.line_end  = line_end_in;
				want.frame_end = frame_end_in;
				expected_pixels.push_back(want);
				if (frame_end_in) begin
					row_odd = 1'b0;
					col_odd = 1'b0;
				end else if (line_end_in) begin
					row_odd = ~row_odd;
					col_odd = 1'b0;
				end else begin
					col_odd = ~col_odd;
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the white balance gain testbench: clock, reset, register settings,
// pixel frames and result draining. Depends on bwb_pkg, bwb_checker and the top level.
module testbench import bwb_pkg::*; ();

	localparam int PB = PIXEL_BITS_DEFAULT;

	// An index past the register list; writes to it must be ignored.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      push;
	logic                      full;
	logic [PB-1:0]             pixel_in;
	logic                      line_end_in;
	logic                      frame_end_in;
	logic                      empty;
	logic                      pop;
	logic [PB-1:0]             pixel_out;
	logic                      line_end_out;
	logic                      frame_end_out;

	int mismatches;
	int pending;
	int compared;
	int sent_count     = 0;
	int settings_count = 0;
	int cur_depth      = DEPTH_RESET;
	bit no_idle        = 1'b0;
	bit rx_hold_req    = 1'b0;

	always #1 clk = ~clk;

	bayer_white_balance_gain u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.pixel_in(pixel_in), .line_end_in(line_end_in), .frame_end_in(frame_end_in),
		.empty(empty), .pop(pop),
		.pixel_out(pixel_out), .line_end_out(line_end_out), .frame_end_out(frame_end_out)
	);

	bwb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.pixel_in(pixel_in), .line_end_in(line_end_in), .frame_end_in(frame_end_in),
		.empty(empty), .pop(pop),
		.pixel_out(pixel_out), .line_end_out(line_end_out), .frame_end_out(frame_end_out),
		.mismatches(mismatches), .pending(pending), .compared(compared)
	);

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Pixel value: zero, full scale, any 24-bit value, or one within the sensor depth.
	function automatic logic [PB-1:0] pick_pixel(input int bits);
		logic [PB-1:0] mask;
		int            r;
		if (bits < 1)
			bits = 1;
		if (bits > PB)
			bits = PB;
		mask = PB'((32'd1 << bits) - 32'd1);
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return PB'($urandom);
		if (r == 5)
			return mask;
		return PB'($urandom) & mask;
	endfunction

	// Offer one item and hold it until the block takes it.
	task automatic put_pixel(input logic [PB-1:0] pix, input logic le, input logic fe);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		pixel_in     <= pix;
		line_end_in  <= le;
		frame_end_in <= fe;
		do
			@(posedge clk);
		while (full);
		sent_count++;
	endtask

	// One register write; the caller lowers the write enable after its batch.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Write every register, plus a spare index that must have no effect.
	task automatic apply_settings(input logic [15:0] en_w, input logic [15:0] cfa_w,
			input logic [15:0] red_w, input logic [15:0] blue_w, input logic [15:0] depth_w);
		write_reg(REG_SPARE, 16'($urandom));
		write_reg(REG_ENABLE, en_w);
		write_reg(REG_CFA, cfa_w);
		write_reg(REG_R_GAIN, red_w);
		write_reg(REG_B_GAIN, blue_w);
		write_reg(REG_PX_DEPTH, depth_w);
		cfg_we <= 1'b0;
		cur_depth = depth_w[DEPTH_BITS-1:0];
		settings_count++;
	endtask

	// Stop offering, wait for every result, then let the pipeline settle.
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (6) @(posedge clk);
	endtask

	// Gain word: the extremes, unity, near unity or anything.
	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return GAIN_RESET;
			3:       return 16'($urandom_range(2048, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	// Random settings with stray upper bits; the first and last phases use extremes.
	task automatic random_settings(input int ph);
		logic [15:0] en_w;
		logic [15:0] cfa_w;
		logic [15:0] depth_w;
		logic [15:0] red_w;
		logic [15:0] blue_w;
		en_w    = 16'($urandom);
		cfa_w   = 16'($urandom);
		depth_w = 16'($urandom);
		en_w[0] = (ph != 3);
		red_w   = pick_gain();
		blue_w  = pick_gain();
		depth_w[DEPTH_BITS-1:0] = DEPTH_BITS'($urandom_range(0, 31));
		if (ph == 0) begin
			red_w  = 16'h0000;
			blue_w = 16'hFFFF;
			depth_w[DEPTH_BITS-1:0] = 5'd1;
		end else if (ph == 5) begin
			red_w  = 16'hFFFF;
			blue_w = 16'hFFFF;
			depth_w[DEPTH_BITS-1:0] = 5'd24;
		end
		apply_settings(en_w, cfa_w, red_w, blue_w, depth_w);
	endtask

	// One frame of small random size; now and then the marks are scrambled.
	task automatic send_frame();
		int   cols;
		int   rows;
		bit   broken;
		logic le;
		logic fe;
		cols   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
		rows   = $urandom_range(1, 5);
		broken = ($urandom_range(0, 9) == 0);
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				le = (c == cols - 1);
				fe = le && (r == rows - 1);
				if (fe && $urandom_range(0, 7) == 0)
					le = 1'b0;
				if (broken) begin
					le = ($urandom_range(0, 3) == 0);
					fe = ($urandom_range(0, 7) == 0);
				end
				put_pixel(pick_pixel(cur_depth), le, fe);
			end
		end
	endtask

	// Result side: pops in bursts with random gaps, and one long hold on request.
	initial begin
		int busy;
		int idle;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		pop <= 1'b1;
		forever begin
			busy = $urandom_range(1, 12);
			repeat (busy) @(posedge clk);
			idle = pick_gap();
			if (rx_hold_req) begin
				idle        = 200;
				rx_hold_req = 1'b0;
			end
			if (idle > 0) begin
				pop <= 1'b0;
				repeat (idle) @(posedge clk);
				pop <= 1'b1;
			end
		end
	end

	// Main sequence: directed frames, then random phases under new settings.
	initial begin
		int start;
		arst_n       <= 1'b0;
		push         <= 1'b0;
		pixel_in     <= '0;
		line_end_in  <= 1'b0;
		frame_end_in <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_ENABLE;
		cfg_data     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: RGGB, unity gains, 12 bits; green is clipped too.
		put_pixel(24'hFFFFFF, 1'b0, 1'b0);
		put_pixel(24'h000FFF, 1'b0, 1'b0);
		put_pixel(24'h001000, 1'b0, 1'b0);
		put_pixel(24'h000000, 1'b1, 1'b0);
		put_pixel(24'h800000, 1'b0, 1'b0);
		put_pixel(24'h000FFF, 1'b0, 1'b0);
		put_pixel(24'h000001, 1'b0, 1'b0);
		put_pixel(24'hABCDEF, 1'b1, 1'b1);
		drain();

		// GRBG, largest red gain, zero blue gain, full 24-bit range; frame end without line end.
		apply_settings(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFF8);
		put_pixel(24'hFFFFFF, 1'b0, 1'b0);
		put_pixel(24'hFFFFFF, 1'b0, 1'b0);
		put_pixel(24'h123456, 1'b1, 1'b0);
		put_pixel(24'hFFFFFF, 1'b0, 1'b0);
		put_pixel(24'h7FFFFF, 1'b0, 1'b0);
		put_pixel(24'hFFFFFF, 1'b0, 1'b1);
		drain();

		// GBRG, gains that land exactly on a half, depth zero acting as one bit.
		apply_settings(16'h0001, 16'h0003, 16'h0800, 16'h1800, 16'hFFE0);
		put_pixel(24'h000001, 1'b0, 1'b0);
		put_pixel(24'h000003, 1'b1, 1'b0);
		put_pixel(24'h000001, 1'b0, 1'b0);
		put_pixel(24'hFFFFFF, 1'b1, 1'b1);
		drain();

		// Disabled with stray bits, depth above the port width: plain pass-through.
		apply_settings(16'hFFFE, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h001F);
		put_pixel(24'hFFFFFF, 1'b0, 1'b0);
		put_pixel(24'h000000, 1'b1, 1'b0);
		put_pixel(24'hA5A5A5, 1'b0, 1'b0);
		put_pixel(24'h5A5A5A, 1'b1, 1'b1);
		drain();

		// Random phases; two include a long result stall, one runs with no idling.
		for (int ph = 0; ph < 6; ph++) begin
			random_settings(ph);
			no_idle = (ph == 2);
			if (ph == 1 || ph == 4)
				rx_hold_req = 1'b1;
			start = sent_count;
			while (sent_count - start < 215)
				send_frame();
			drain();
		end

		$display("Run covered %0d pixels under %0d register settings, %0d results compared.",
			sent_count, settings_count, compared);
		$display("Settings included pass-through, clamped bit depths, extreme gains and stalls.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/bwb_pkg.sv
design/bwb_fifo.sv
design/bwb_front.sv
design/bwb_back.sv
design/bayer_white_balance_gain.sv
tb/bwb_checker.sv
tb/testbench.sv
